>>> src/bhtle_pkg.sv
// Shared types and constants for the bucketed hash table core.
// No dependencies; used by the controller, the datapath and the top level.
package bhtle_pkg;

    localparam int TABLE_ENTRIES = 4096;   // power of two: bucket start is a bit-select
    localparam int BUCKET_SLOTS  = 4;
    localparam int PAYLOAD_BITS  = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PK_W          = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int FILL_W        = 13;

    localparam logic [63:0] GOLDEN_MUL = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

    localparam logic [1:0] RND_GOLD = 2'd0;
    localparam logic [1:0] RND_A    = 2'd1;
    localparam logic [1:0] RND_B    = 2'd2;

    localparam logic KIND_LOOKUP = 1'b0;

    typedef struct packed {
        logic                    valid;
        logic [63:0]             key_low;
        logic [63:0]             key_high;
        logic [31:0]             work;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_slot;

    typedef struct packed {
        logic clr;      // write one cleared slot, advance sweep
        logic load;     // latch request
        logic mul;      // partial products
        logic sum;      // finish product, mix step
        logic issue;    // memory read of next probe slot
        logic write;    // commit store
    } t_ctl;

    typedef struct packed {
        logic clr_last;
        logic rnd_last;
        logic probe_last;
        logic kind;
    } t_sts;

    function automatic logic [63:0] mix_const(input logic [1:0] rnd);
        logic [63:0] c;
        case (rnd)
            RND_GOLD: c = GOLDEN_MUL;
            RND_A:    c = MIX_MUL_A;
            default:  c = MIX_MUL_B;
        endcase
        return c;
    endfunction

endpackage

>>> src/bhtle_ctrl.sv
// Sequencing state machine for the bucketed hash table core.
// Depends on bhtle_pkg; drives the datapath through bhtle_pkg::t_ctl.
module bhtle_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  bhtle_pkg::t_sts i_sts,
    output bhtle_pkg::t_ctl o_ctl,
    output logic            busy,
    output logic            o_valid
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_SUM   = 8'b0000_1000,
        S_PROBE = 8'b0001_0000,
        S_LAST  = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_ctl.sum = 1'b1;
                n_state   = i_sts.rnd_last ? S_PROBE : S_MUL;
            end
            S_PROBE: begin
                o_ctl.issue = 1'b1;
                if (i_sts.probe_last) n_state = S_LAST;
            end
            S_LAST: begin
                n_state = (i_sts.kind == bhtle_pkg::KIND_LOOKUP) ? S_DONE : S_WRITE;
            end
            S_WRITE: begin
                o_ctl.write = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

>>> src/bhtle_dp.sv
// Datapath: key hash with split 32x32 products, slot memory, probe evaluation.
// Depends on bhtle_pkg; commanded by bhtle_ctrl.
module bhtle_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bhtle_pkg::t_ctl                    i_ctl,
    output bhtle_pkg::t_sts                    o_sts,
    input  logic                               i_kind,
    input  logic [63:0]                        i_key_low,
    input  logic [63:0]                        i_key_high,
    input  logic [31:0]                        i_work_in,
    input  logic [bhtle_pkg::PAYLOAD_BITS-1:0] i_payload_in,
    output logic                               o_hit,
    output logic [31:0]                        o_found_work,
    output logic [31:0]                        o_found_payload,
    output logic [bhtle_pkg::FILL_W-1:0]       o_fill_count
);

    localparam int IW = bhtle_pkg::IDX_W;
    localparam int KW = bhtle_pkg::PK_W;

    bhtle_pkg::t_slot r_mem [bhtle_pkg::TABLE_ENTRIES];

    logic        r_kind;
    logic [63:0] r_klo, r_khi, r_h;
    logic [31:0] r_work;
    logic [bhtle_pkg::PAYLOAD_BITS-1:0] r_pay;
    logic [1:0]  r_rnd;
    logic [63:0] r_pp0;
    logic [31:0] r_pp1, r_pp2;
    logic [KW-1:0] r_k;
    logic [IW-1:0] r_clr, r_rd_addr;
    logic          r_rd_v;
    bhtle_pkg::t_slot r_rd;

    logic          r_m, r_e;
    logic [IW-1:0] r_mi, r_ei, r_mini;
    logic [31:0]   r_minw, r_fw, r_fp;
    logic [bhtle_pkg::FILL_W-1:0] r_fill;

    logic [63:0] mul_a, mul_c, prod, x, n_h;
    logic [IW-1:0] probe_addr, tgt, mem_addr;
    bhtle_pkg::t_slot wdata;
    logic rd_match;

    assign mul_a = (r_rnd == bhtle_pkg::RND_GOLD) ? r_khi : r_h;
    assign mul_c = bhtle_pkg::mix_const(r_rnd);
    assign prod  = r_pp0 + {r_pp1 + r_pp2, 32'd0};

    always_comb begin
        case (r_rnd)
            bhtle_pkg::RND_GOLD: begin
                x   = r_klo ^ prod;
                n_h = x ^ (x >> 30);
            end
            bhtle_pkg::RND_A: begin
                x   = prod;
                n_h = x ^ (x >> 27);
            end
            default: begin
                x   = prod;
                n_h = x ^ (x >> 31);
            end
        endcase
    end

    // table size is a power of two, so start and wrap are bit-selects
    assign probe_addr = r_h[IW-1:0] + IW'(r_k);
    assign tgt        = r_m ? r_mi : (r_e ? r_ei : r_mini);
    assign mem_addr   = i_ctl.clr ? r_clr : (i_ctl.write ? tgt : probe_addr);

    always_comb begin
        wdata          = '0;
        wdata.valid    = i_ctl.write;
        wdata.key_low  = r_klo;
        wdata.key_high = r_khi;
        wdata.work     = r_work;
        wdata.payload  = r_pay;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr || i_ctl.write) begin
            r_mem[mem_addr] <= wdata;
        end
        if (i_ctl.issue) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    assign rd_match = r_rd.valid && r_rd.key_low == r_klo && r_rd.key_high == r_khi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_fill <= '0;
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_ctl.issue;
            if (i_ctl.clr) r_clr <= r_clr + 1'b1;
            if (i_ctl.write && !r_m && r_e) r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_kind <= i_kind;
            r_klo  <= i_key_low;
            r_khi  <= i_key_high;
            r_work <= i_work_in;
            r_pay  <= i_payload_in;
            r_rnd  <= bhtle_pkg::RND_GOLD;
            r_k    <= '0;
            r_m    <= 1'b0;
            r_e    <= 1'b0;
            r_minw <= '1;
            r_fw   <= '0;
            r_fp   <= '0;
        end
        if (i_ctl.mul) begin
            r_pp0 <= {32'd0, mul_a[31:0]} * {32'd0, mul_c[31:0]};
            r_pp1 <= mul_a[31:0] * mul_c[63:32];
            r_pp2 <= mul_a[63:32] * mul_c[31:0];
        end
        if (i_ctl.sum) begin
            r_h   <= n_h;
            r_rnd <= r_rnd + 2'd1;
        end
        if (i_ctl.issue) begin
            r_rd_addr <= probe_addr;
            r_k       <= r_k + 1'b1;
            if (r_k == '0) r_mini <= probe_addr;
        end
        // first match stops the evaluation; later slots change nothing
        if (r_rd_v && !r_m) begin
            if (rd_match) begin
                r_m  <= 1'b1;
                r_mi <= r_rd_addr;
                r_fw <= r_rd.work;
                r_fp <= 32'(r_rd.payload);
            end else if (!r_rd.valid) begin
                if (!r_e) begin
                    r_e  <= 1'b1;
                    r_ei <= r_rd_addr;
                end
            end else if (r_rd.work < r_minw) begin
                r_minw <= r_rd.work;
                r_mini <= r_rd_addr;
            end
        end
    end

    assign o_sts.clr_last   = (r_clr == IW'(bhtle_pkg::TABLE_ENTRIES - 1));
    assign o_sts.rnd_last   = (r_rnd == bhtle_pkg::RND_B);
    assign o_sts.probe_last = (r_k == KW'(bhtle_pkg::BUCKET_SLOTS - 1));
    assign o_sts.kind       = r_kind;

    assign o_hit           = r_m;
    assign o_found_work    = (r_kind == bhtle_pkg::KIND_LOOKUP) ? r_fw : 32'd0;
    assign o_found_payload = (r_kind == bhtle_pkg::KIND_LOOKUP) ? r_fp : 32'd0;
    assign o_fill_count    = r_fill;

endmodule

>>> src/bucketed_hash_table_least_work_evict_core.sv
// Top level of the bucketed hash table with least-work eviction.
// Depends on bhtle_pkg, bhtle_ctrl and bhtle_dp.

// After reset the core sweeps all 4096 slots to clear them, holding busy high
// until the sweep is done. Each request then runs through these steps: three
// 64-bit hash products, each as a multiply step and a sum step, four reads of the
// single-port slot memory, one evaluation step, one write on a store only, and
// the result beat. Busy drops in the cycle after the strobe. One request is in
// flight at a time. o_valid marks the result beat for exactly one cycle; the
// receiver cannot stall it.
module bucketed_hash_table_least_work_evict_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_kind,
    input  logic [63:0]                        i_key_low,
    input  logic [63:0]                        i_key_high,
    input  logic [31:0]                        i_work_in,
    input  logic [bhtle_pkg::PAYLOAD_BITS-1:0] i_payload_in,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic [31:0]                        o_found_work,
    output logic [31:0]                        o_found_payload,
    output logic [bhtle_pkg::FILL_W-1:0]       o_fill_count
);

    bhtle_pkg::t_ctl ctl;
    bhtle_pkg::t_sts sts;

    bhtle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .busy    (busy),
        .o_valid (o_valid)
    );

    bhtle_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_kind          (i_kind),
        .i_key_low       (i_key_low),
        .i_key_high      (i_key_high),
        .i_work_in       (i_work_in),
        .i_payload_in    (i_payload_in),
        .o_hit           (o_hit),
        .o_found_work    (o_found_work),
        .o_found_payload (o_found_payload),
        .o_fill_count    (o_fill_count)
    );

endmodule
